// File: rtl/core/slru_pkg.sv
package slru_pkg;

    localparam int NUM_SETS = 64;
    localparam int MAX_WAYS = 4;
    localparam int TAG_BITS = 11;

    localparam int SET_W  = 6;
    localparam int CFG_W  = 3;
    localparam int RANK_W = 2;
    localparam int CNT_W  = 32;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam int POS_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int IDX_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    localparam logic [CFG_W-1:0] WAYS_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [WAYS_W-1:0]                 occ;
        logic [MAX_WAYS-1:0][TAG_BITS-1:0] tags;
    } t_row;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/slru_ctrl.sv
module slru_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  slru_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output slru_pkg::t_cmd o_cmd
);
    import slru_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.accept = 1'b0;
        o_cmd.lookup = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/slru_dp.sv
module slru_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slru_pkg::t_cmd                i_cmd,
    output slru_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [slru_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [slru_pkg::TAG_BITS-1:0] i_access_tag,
    input  logic [slru_pkg::SET_W-1:0]    i_set_index,
    input  logic                          i_final_access,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [slru_pkg::RANK_W-1:0]   o_hit_rank,
    output logic [slru_pkg::CNT_W-1:0]    o_miss_count,
    output logic                          o_trace_done
);
    import slru_pkg::*;

    t_row                r_mem [NUM_SETS];
    t_row                r_rd;
    logic [NUM_SETS-1:0] r_valid;
    logic [CFG_W-1:0]    r_ways;
    logic [CNT_W-1:0]    r_miss;

    logic [TAG_BITS-1:0] r_tag;
    logic [IDX_W-1:0]    r_set;
    logic                r_fin;

    t_row                r_new_row;
    logic                r_hit;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_miss_next;

    logic                r_out_valid;
    logic                r_out_hit;
    logic [RANK_W-1:0]   r_out_rank;
    logic [CNT_W-1:0]    r_out_miss;
    logic                r_out_done;

    logic [WAYS_W-1:0]   ways_eff;
    logic [WAYS_W-1:0]   occ;
    logic [WAYS_W-1:0]   limit;
    logic                found;
    logic [POS_W-1:0]    pos;
    t_row                n_row;
    logic [IDX_W-1:0]    in_set;

    assign in_set = IDX_W'(32'(i_set_index) % NUM_SETS);

    always_comb begin
        if (r_ways == '0) begin
            ways_eff = WAYS_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_W'(r_ways);
        end
    end

    always_comb begin
        occ = '0;
        if (r_valid[r_set]) begin
            occ = (r_rd.occ > ways_eff) ? ways_eff : r_rd.occ;
        end
        found = 1'b0;
        pos   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (WAYS_W'(i) < occ && r_rd.tags[i] == r_tag) begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
        if (found) begin
            limit = WAYS_W'(pos);
        end else if (occ >= ways_eff) begin
            limit = ways_eff - WAYS_W'(1);
        end else begin
            limit = occ;
        end
        n_row.tags[0] = r_tag;
        for (int i = 1; i < MAX_WAYS; i++) begin
            n_row.tags[i] = (WAYS_W'(i) <= limit) ? r_rd.tags[i-1] : r_rd.tags[i];
        end
        n_row.occ = found ? occ : limit + WAYS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[in_set];
        end
        if (i_cmd.commit) begin
            r_mem[r_set] <= r_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag <= i_access_tag;
            r_set <= in_set;
            r_fin <= i_final_access;
        end
        if (i_cmd.lookup) begin
            r_new_row <= n_row;
            r_hit     <= found;
            r_pos     <= pos;
            if (found || r_miss == '1) begin
                r_miss_next <= r_miss;
            end else begin
                r_miss_next <= r_miss + CNT_W'(1);
            end
        end
        if (i_cmd.commit) begin
            r_out_hit  <= r_hit;
            r_out_rank <= r_hit ? RANK_W'(r_pos) : '0;
            r_out_miss <= r_miss_next;
            r_out_done <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ways      <= WAYS_RESET;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ways <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                if (r_fin) begin
                    r_valid <= '0;
                    r_miss  <= '0;
                end else begin
                    r_valid[r_set] <= 1'b1;
                    r_miss         <= r_miss_next;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_hit_rank   = r_out_rank;
    assign o_miss_count = r_out_miss;
    assign o_trace_done = r_out_done;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed item not presented");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_fin) |=> (r_miss == '0 && r_valid == '0))
        else $error("final item left state behind");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> (r_new_row.occ != '0 && 32'(r_new_row.occ) <= MAX_WAYS))
        else $error("set occupancy out of range");

endmodule

// File: rtl/core/set_associative_lru_miss_counter_top.sv
// Set-associative LRU lookup with a saturating miss counter. Each item is one
// access (tag, set, final mark) and yields one result: hit, recency rank of the
// hit and the running miss count. An item passes through a registered read
// of the set's row from the tag store, the compare and reorder, then the write
// back together with loading the output register; a new item is taken once the
// previous one has written back. A result waiting under i_out_stall holds the
// write-back stage. After a final item every set empties and the count returns
// to zero at once. Write ways_in_use through i_cfg_we/i_cfg_data only when idle.
module set_associative_lru_miss_counter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slru_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [slru_pkg::TAG_BITS-1:0] i_access_tag,
    input  logic [slru_pkg::SET_W-1:0]    i_set_index,
    input  logic                          i_final_access,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [slru_pkg::RANK_W-1:0]   o_hit_rank,
    output logic [slru_pkg::CNT_W-1:0]    o_miss_count,
    output logic                          o_trace_done
);
    import slru_pkg::*;

    t_cmd cmd;
    t_sts sts;

    slru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    slru_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_access_tag   (i_access_tag),
        .i_set_index    (i_set_index),
        .i_final_access (i_final_access),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_hit_rank     (o_hit_rank),
        .o_miss_count   (o_miss_count),
        .o_trace_done   (o_trace_done)
    );

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slru_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int CHUNK_ITEMS  = 170;
    localparam int NUM_CHUNKS   = 9;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic                hit;
        logic [RANK_W-1:0]   rank;
        logic [CNT_W-1:0]    count;
        logic                done;
    } t_lookup;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [SET_W-1:0]    set_idx;
        logic                fin;
        logic                wr_ways;
        logic [CFG_W-1:0]    ways;
        logic                known;
        logic                hit;
        logic [RANK_W-1:0]   rank;
        logic [CNT_W-1:0]    count;
        logic                done;
    } t_access_row;

    localparam t_access_row DIRECTED [27] = '{
        '{0,    0,  0, 0, 0, 1, 0, 0, 1, 0},
        '{2047, 63, 0, 0, 0, 1, 0, 0, 2, 0},
        '{0,    0,  0, 0, 0, 1, 1, 0, 2, 0},
        '{2047, 0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{1,    0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{2,    0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{0,    0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{3,    0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{2047, 0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{2047, 63, 1, 0, 0, 1, 1, 0, 7, 1},
        '{0,    0,  0, 0, 0, 1, 0, 0, 1, 0},
        '{1365, 42, 0, 0, 0, 0, 0, 0, 0, 0},
        '{682,  21, 0, 0, 0, 0, 0, 0, 0, 0},
        '{5,    1,  0, 0, 0, 0, 0, 0, 0, 0},
        '{6,    1,  0, 0, 0, 0, 0, 0, 0, 0},
        '{7,    1,  0, 0, 0, 0, 0, 0, 0, 0},
        '{8,    1,  0, 0, 0, 0, 0, 0, 0, 0},
        '{5,    1,  0, 1, 2, 0, 0, 0, 0, 0},
        '{7,    1,  0, 0, 0, 0, 0, 0, 0, 0},
        '{9,    2,  0, 1, 0, 0, 0, 0, 0, 0},
        '{10,   2,  0, 0, 0, 0, 0, 0, 0, 0},
        '{9,    2,  0, 0, 0, 0, 0, 0, 0, 0},
        '{11,   3,  0, 1, 7, 0, 0, 0, 0, 0},
        '{12,   3,  0, 0, 0, 0, 0, 0, 0, 0},
        '{13,   3,  0, 0, 0, 0, 0, 0, 0, 0},
        '{14,   3,  0, 0, 0, 0, 0, 0, 0, 0},
        '{11,   3,  1, 0, 0, 0, 0, 0, 0, 0}
    };

    localparam logic [CFG_W-1:0] CHUNK_WAYS [NUM_CHUNKS] = '{1, 4, 2, 3, 0, 7, 4, 3, 2};

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [TAG_BITS-1:0] i_access_tag   = '0;
    logic [SET_W-1:0]    i_set_index    = '0;
    logic                i_final_access = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic                o_hit;
    logic [RANK_W-1:0]   o_hit_rank;
    logic [CNT_W-1:0]    o_miss_count;
    logic                o_trace_done;

    logic [TAG_BITS-1:0] cache_tags [NUM_SETS][MAX_WAYS];
    int                  cache_occ [NUM_SETS];
    logic [CNT_W-1:0]    cache_misses;
    logic [CFG_W-1:0]    cache_ways_cfg;

    t_lookup             pending_lookups [$];
    int                  mismatches;
    int                  cycles;
    int                  sender_idle_pct;
    int                  receiver_idle_pct;
    bit                  hold_request;
    int                  hold_left;

    set_associative_lru_miss_counter_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_access_tag   (i_access_tag),
        .i_set_index    (i_set_index),
        .i_final_access (i_final_access),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_hit_rank     (o_hit_rank),
        .o_miss_count   (o_miss_count),
        .o_trace_done   (o_trace_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_lookup lru_lookup(input logic [TAG_BITS-1:0] tag,
                                           input logic [SET_W-1:0] set_idx,
                                           input logic fin);
        int      ways;
        int      occ;
        int      pos;
        bit      found;
        t_lookup r;
        ways  = (cache_ways_cfg < 1) ? 1 :
                (cache_ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(cache_ways_cfg);
        occ   = cache_occ[set_idx];
        found = 1'b0;
        pos   = 0;
        if (occ > ways) occ = ways;
        for (int i = 0; i < occ; i++) begin
            if (!found && cache_tags[set_idx][i] == tag) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (!found) begin
            if (occ >= ways) occ = ways - 1;
            pos = occ;
            occ++;
            if (cache_misses != '1) cache_misses++;
        end
        for (int i = pos; i > 0; i--) cache_tags[set_idx][i] = cache_tags[set_idx][i-1];
        cache_tags[set_idx][0] = tag;
        cache_occ[set_idx]     = occ;
        r.hit   = found;
        r.rank  = found ? RANK_W'(pos) : '0;
        r.count = cache_misses;
        r.done  = fin;
        if (fin) begin
            foreach (cache_occ[k]) cache_occ[k] = 0;
            cache_misses = '0;
        end
        return r;
    endfunction

    function automatic void queue_lookup(input t_lookup item);
        pending_lookups.insert(pending_lookups.size(), item);
    endfunction

    task automatic offer_access(input logic [TAG_BITS-1:0] tag,
                                input logic [SET_W-1:0] set_idx,
                                input logic fin,
                                output t_lookup predicted);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_access_tag   <= tag;
        i_set_index    <= set_idx;
        i_final_access <= fin;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = lru_lookup(tag, set_idx, fin);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ways(input logic [CFG_W-1:0] ways);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ways;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cache_ways_cfg  = ways;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_lookups.size() == 0) begin
                $error("result with no access outstanding");
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    mismatches++;
                end
                if (o_hit_rank !== want.rank) begin
                    $error("hit_rank: expected %0d, got %0d", want.rank, o_hit_rank);
                    mismatches++;
                end
                if (o_miss_count !== want.count) begin
                    $error("miss_count: expected %0d, got %0d", want.count, o_miss_count);
                    mismatches++;
                end
                if (o_trace_done !== want.done) begin
                    $error("trace_done: expected %0d, got %0d", want.done, o_trace_done);
                    mismatches++;
                end
            end
        end
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (receiver_idle_pct > 0) &&
                           ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    initial begin
        t_lookup             predicted;
        t_lookup             typed;
        int                  trace_left;
        logic [TAG_BITS-1:0] tag_base;
        logic [SET_W-1:0]    set_base;
        logic [TAG_BITS-1:0] tag;
        logic [SET_W-1:0]    set_idx;
        logic                fin;

        foreach (cache_occ[k]) cache_occ[k] = 0;
        cache_misses      = '0;
        cache_ways_cfg    = WAYS_RESET;
        mismatches        = 0;
        cycles            = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b0;
        hold_left         = 0;
        trace_left        = 0;
        tag_base          = '0;
        set_base          = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].wr_ways) write_ways(DIRECTED[k].ways);
            offer_access(DIRECTED[k].tag, DIRECTED[k].set_idx, DIRECTED[k].fin, predicted);
            if (DIRECTED[k].known) begin
                typed.hit   = DIRECTED[k].hit;
                typed.rank  = DIRECTED[k].rank;
                typed.count = DIRECTED[k].count;
                typed.done  = DIRECTED[k].done;
                queue_lookup(typed);
            end else begin
                queue_lookup(predicted);
            end
        end

        for (int c = 0; c < NUM_CHUNKS; c++) begin
            write_ways(CHUNK_WAYS[c]);
            sender_idle_pct   = (c < 3) ? 37 : (c < 6) ? 71 : 0;
            receiver_idle_pct = (c < 3) ? 71 : (c < 6) ? 37 : 0;
            if (c == 6) hold_request = 1'b1;
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                if (c == 4 && n == 60) quiesce();
                if (trace_left == 0) begin
                    trace_left = $urandom_range(8, 90);
                    tag_base   = TAG_BITS'($urandom_range(0, 2047));
                    set_base   = SET_W'($urandom_range(0, 63));
                end
                tag     = ($urandom_range(0, 99) < 80) ?
                          tag_base ^ TAG_BITS'($urandom_range(0, 5)) :
                          TAG_BITS'($urandom_range(0, 2047));
                set_idx = ($urandom_range(0, 99) < 75) ?
                          set_base ^ SET_W'($urandom_range(0, 3)) :
                          SET_W'($urandom_range(0, 63));
                fin     = (trace_left == 1) || ($urandom_range(0, 99) == 0);
                trace_left = fin ? 0 : trace_left - 1;
                offer_access(tag, set_idx, fin, predicted);
                queue_lookup(predicted);
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
